// File: hw/rtl/wpm_pkg.sv
// shared types and constants of the wildcard pattern matcher
package wpm_pkg;

	// code point width and the two glob characters
	localparam int CP_W = 21;
	localparam logic [CP_W-1:0] GLOB_STAR = 21'd42;
	localparam logic [CP_W-1:0] GLOB_ONE = 21'd63;

	// request kinds carried on s_tuser
	localparam int REQ_W = 2;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
	localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TARGET = 2'd2;
	localparam logic [REQ_W-1:0] REQ_END = 2'd3;

	// stream data widths, padded to whole bytes
	localparam int IN_DATA_W = 48;
	localparam int OUT_DATA_W = 8;

	// queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W = $clog2(Q_DEPTH);
	localparam int QCNT_W = $clog2(Q_DEPTH + 1);

	// classified request as held in the queue
	typedef struct packed {
		logic [REQ_W-1:0] op;
		logic [CP_W-1:0] chr;
		logic is_star;
		logic is_one;
	} item_t;

	// queue head as seen by the back part
	typedef struct packed {
		logic valid;
		item_t item;
	} head_t;

endpackage

// File: hw/rtl/wpm_front.sv
// front part: accepts request beats, classifies them and queues them
module wpm_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [wpm_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic [wpm_pkg::REQ_W-1:0]         s_tuser,
	output wpm_pkg::head_t                    head,
	input  logic                              pop
);

	wpm_pkg::item_t                     mem_q [wpm_pkg::Q_DEPTH];
	logic [wpm_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [wpm_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [wpm_pkg::QCNT_W-1:0]         cnt_q;
	wpm_pkg::item_t                     in_item;
	logic                               push;

	// append carries the pattern code point, everything else the target one
	always_comb begin
		in_item.op = s_tuser;
		if (s_tuser == wpm_pkg::REQ_APPEND) begin
			in_item.chr = s_tdata[wpm_pkg::CP_W-1:0];
		end else begin
			in_item.chr = s_tdata[2*wpm_pkg::CP_W-1:wpm_pkg::CP_W];
		end
		in_item.is_star = (in_item.chr == wpm_pkg::GLOB_STAR);
		in_item.is_one = (in_item.chr == wpm_pkg::GLOB_ONE);
	end

	assign s_tready = (cnt_q != wpm_pkg::QCNT_W'(wpm_pkg::Q_DEPTH));
	assign push = s_tvalid && s_tready;

	assign head.valid = (cnt_q != '0);
	assign head.item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == wpm_pkg::QPTR_W'(wpm_pkg::Q_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (pop) begin
				if (rd_ptr_q == wpm_pkg::QPTR_W'(wpm_pkg::Q_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			case ({push, pop})
				2'b10: begin
					cnt_q <= cnt_q + 1'b1;
				end
				2'b01: begin
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/wpm_back.sv
// back part: pattern store, prefix vector update and result register
module wpm_back #(
	parameter int MAX_PATTERN = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  wpm_pkg::head_t                    head,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [wpm_pkg::OUT_DATA_W-1:0]    m_tdata
);

	localparam int N = MAX_PATTERN + 1;
	localparam int LV = $clog2(N);

	logic [MAX_PATTERN-1:0][wpm_pkg::CP_W-1:0] chr_q;
	logic [MAX_PATTERN-1:0]                    star_q;
	logic [MAX_PATTERN-1:0]                    one_q;
	logic [MAX_PATTERN-1:0]                    used_q;
	logic [MAX_PATTERN:0]                      end_q;
	logic [MAX_PATTERN:0]                      raw_q;
	logic [MAX_PATTERN:0]                      raw_nxt;
	logic [MAX_PATTERN:0]                      closed;
	logic                                      too_long_q;
	logic                                      out_valid_q;
	logic [wpm_pkg::OUT_DATA_W-1:0]            out_data_q;
	logic [LV:0][N-1:0]                        gl;
	logic [LV:0][N-1:0]                        pl;
	logic                                      out_free;
	logic                                      match_now;
	logic                                      is_append;

	// star closure as a parallel prefix: bit j takes bit j-1 through a star entry
	assign gl[0] = raw_q;
	assign pl[0] = {used_q & star_q, 1'b0};

	for (genvar l = 0; l < LV; l++) begin : g_lvl
		for (genvar j = 0; j < N; j++) begin : g_bit
			if (j >= (1 << l)) begin : g_op
				assign gl[l+1][j] = gl[l][j] | (pl[l][j] & gl[l][j-(1<<l)]);
				assign pl[l+1][j] = pl[l][j] & pl[l][j-(1<<l)];
			end else begin : g_pass
				assign gl[l+1][j] = gl[l][j];
				assign pl[l+1][j] = pl[l][j];
			end
		end
	end

	assign closed = gl[LV];

	always_comb begin
		raw_nxt[0] = 1'b0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (star_q[i]) begin
				raw_nxt[i+1] = used_q[i] & closed[i+1];
			end else begin
				raw_nxt[i+1] = used_q[i] & closed[i]
					& (one_q[i] | (chr_q[i] == head.item.chr));
			end
		end
	end

	assign match_now = !too_long_q && (|(closed & end_q));

	assign out_free = !out_valid_q || m_tready;
	assign pop = head.valid && ((head.item.op != wpm_pkg::REQ_END) || out_free);
	assign is_append = pop && (head.item.op == wpm_pkg::REQ_APPEND);

	// pattern entries, written at the slot marked by the one-hot length
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (is_append && end_q[i]) begin
				chr_q[i] <= head.item.chr;
				star_q[i] <= head.item.is_star;
				one_q[i] <= head.item.is_one;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			end_q <= (MAX_PATTERN+1)'(1);
			raw_q <= (MAX_PATTERN+1)'(1);
			too_long_q <= 1'b0;
		end else if (pop) begin
			case (head.item.op)
				wpm_pkg::REQ_CLEAR: begin
					used_q <= '0;
					end_q <= (MAX_PATTERN+1)'(1);
					raw_q <= (MAX_PATTERN+1)'(1);
					too_long_q <= 1'b0;
				end
				wpm_pkg::REQ_APPEND: begin
					if (end_q[MAX_PATTERN]) begin
						too_long_q <= 1'b1;
					end else begin
						used_q <= used_q | end_q[MAX_PATTERN-1:0];
						end_q <= {end_q[MAX_PATTERN-1:0], 1'b0};
					end
					raw_q <= (MAX_PATTERN+1)'(1);
				end
				wpm_pkg::REQ_TARGET: begin
					raw_q <= raw_nxt;
				end
				default: begin
					raw_q <= (MAX_PATTERN+1)'(1);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && (head.item.op == wpm_pkg::REQ_END)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (head.item.op == wpm_pkg::REQ_END)) begin
			out_data_q <= {(wpm_pkg::OUT_DATA_W-2)'(0), too_long_q, match_now};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

endmodule

// File: hw/rtl/wildcard_pattern_matcher.sv
// top level of the streaming glob matcher over code points
// result path: an end-of-target beat is queued, then popped into the result register
// throughput: one beat per cycle unless a result stalls; combinational prefix update
// a result waiting on m_tready holds the next end-of-target beat at the queue head;
// beats behind it wait too, the two-entry queue fills and s_tready drops
// reset (arst_n low) empties the queue, drops any pending result, clears the pattern
// and leaves only the empty prefix active; stored code points are not cleared
module wildcard_pattern_matcher #(
	parameter int MAX_PATTERN = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [20:0] pattern_char, [41:21] target_char, [47:42] zero
	input  logic [wpm_pkg::IN_DATA_W-1:0]     s_tdata,
	// [1:0] req_type
	input  logic [wpm_pkg::REQ_W-1:0]         s_tuser,
	// result stream, one beat per end of target
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] match, [1] overflow, [7:2] zero
	output logic [wpm_pkg::OUT_DATA_W-1:0]    m_tdata
);

	// queue head handed from front to back, and the back's pop
	wpm_pkg::head_t head;
	logic           pop;

	// front: classify the beat (star, question mark, literal) and queue it
	wpm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.head     (head),
		.pop      (pop)
	);

	// back: pattern store, active prefix vector with star closure, result register
	wpm_back #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// File: hw/rtl/wpm_checker.sv
// port-level checks on the glob matcher and their bind
module wpm_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tready,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [wpm_pkg::OUT_DATA_W-1:0]    m_tdata
);

	// no result survives reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	// an overflowed pattern never reports a match
	a_ovf_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("match reported with overflow");

	// the queue only fills up behind a stalled result
	a_full_needs_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled without a pending result");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
